// ----- rtl/ordd_pkg.sv -----
package ordd_pkg;

  // Field and datapath widths
  localparam int unsigned SAMPLE_W = 10;
  localparam int unsigned LIMIT_W  = 11;
  localparam int unsigned SPEED_W  = 7;
  localparam int unsigned HOLD_W   = 9;
  localparam int unsigned CODE_W   = 8;
  localparam int unsigned DVD_W    = 5;
  localparam int unsigned DSR_W    = 3;
  localparam int unsigned STEP_W   = 3;
  localparam int unsigned DIR_W    = 9;
  localparam int unsigned CORR_W   = 7;
  localparam int unsigned AVG_W    = 4;
  localparam int unsigned CNT_W    = 3;
  localparam int unsigned WSUM_W   = 5;
  localparam int unsigned CFG_IDX_W = 2;
  localparam int unsigned HPROD_W  = 38;
  localparam int unsigned HEAD_SHIFT = 29;
  localparam int unsigned MAG_W    = 8;
  localparam int unsigned CPROD_W  = 16;
  localparam int unsigned CORR_SHIFT = 10;

  typedef logic [SAMPLE_W-1:0] sample_t;
  typedef logic [LIMIT_W-1:0]  limit_t;
  typedef logic [SPEED_W-1:0]  speed_t;
  typedef logic [CODE_W-1:0]   code_t;
  typedef logic [HOLD_W-1:0]   hold_t;
  typedef logic [WSUM_W-1:0]   wsum_t;
  typedef logic [DIR_W-1:0]    dir_t;

  // Pre-clamp level, stored level, heading correction
  typedef logic signed [8:0]        lvl_t;
  typedef logic signed [7:0]        mlev_t;
  typedef logic signed [CORR_W-1:0] corr_t;

  // Configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_LIM_RIGHT = 2'd0,
    REG_LIM_LEFT  = 2'd1,
    REG_LIM_BACK  = 2'd2,
    REG_SPEED     = 2'd3
  } cfg_reg_t;

  // Last action taken from the ball sensors
  typedef enum logic [2:0] {
    ACT_NONE   = 3'd0,
    ACT_CENTRE = 3'd1,
    ACT_UPPER  = 3'd2,
    ACT_LOWER  = 3'd3,
    ACT_AUX    = 3'd4
  } action_t;

  typedef struct packed {
    sample_t heading_raw;
    sample_t line_right;
    sample_t line_left;
    sample_t line_back;
    sample_t ball_one;
    sample_t ball_two;
    sample_t ball_three;
    sample_t ball_four;
    sample_t ball_five;
    sample_t ball_rear;
  } in_item_t;

  typedef struct packed {
    logic  stop_first;
    code_t motor_one_code;
    code_t motor_two_code;
    code_t motor_three_code;
    hold_t hold_ms;
  } out_item_t;

  // Shared divider interface
  typedef struct packed {
    logic              start;
    logic [DVD_W-1:0]  dividend;
    logic [DSR_W-1:0]  divisor;
    logic [STEP_W-1:0] steps;
  } div_req_t;

  typedef struct packed {
    logic             busy;
    logic             done;
    logic [DVD_W-1:0] quotient;
  } div_rsp_t;

  // Decision inputs and outputs
  typedef struct packed {
    logic             line_r;
    logic             line_l;
    logic             line_b;
    logic             window;
    logic             dir_high;
    logic             ball_any;
    logic             rear_seen;
    logic             rear_ord_a;
    logic             rear_ord_b;
    logic [AVG_W-1:0] avg;
    action_t          action;
  } sel_in_t;

  typedef struct packed {
    logic    stop;
    logic    long_hold;
    action_t action;
    lvl_t    lv0;
    lvl_t    lv1;
    lvl_t    lv2;
  } sel_out_t;

  // Constants
  localparam limit_t  LIM_RESET    = 11'd1023;
  localparam speed_t  SPEED_RESET  = 7'd80;
  localparam sample_t BALL_ONE_LIM = 10'd300;
  localparam sample_t BALL_LIM     = 10'd350;
  localparam sample_t REAR_LIM     = 10'd400;
  localparam wsum_t   W_ONE        = 5'd6;
  localparam wsum_t   W_TWO        = 5'd8;
  localparam wsum_t   W_THREE      = 5'd4;
  localparam wsum_t   W_FOUR       = 5'd10;
  localparam wsum_t   W_FIVE       = 5'd2;
  // 360 * ceil(2^29 / 1023): exact floor of reading*360/1023 after the shift
  localparam logic [HPROD_W-1:0] HEAD_RECIP = 38'd188928360;
  // ceil(2^10 / 5): exact floor of x/5 for x up to 255
  localparam logic [CPROD_W-1:0] CORR_RECIP = 16'd205;
  localparam dir_t    DIR_HALF     = 9'd180;
  localparam dir_t    DIR_FULL     = 9'd360;
  localparam dir_t    WIN_LO       = 9'd110;
  localparam dir_t    WIN_HI       = 9'd240;
  localparam lvl_t    LEVEL_MAX    = 9'sd100;
  localparam lvl_t    SLOW_LEVEL   = 9'sd10;
  localparam hold_t   HOLD_LINE    = 9'd500;
  localparam hold_t   HOLD_BALL    = 9'd10;
  localparam code_t   CODE_NEG     = 8'h80;
  localparam logic [STEP_W-1:0] STEPS_AVG  = 3'd5;

  // Saturate a corrected level to +-100
  function automatic mlev_t clamp_level(lvl_t v);
    mlev_t r;
    if (v > LEVEL_MAX) begin
      r = mlev_t'(LEVEL_MAX);
    end else if (v < -LEVEL_MAX) begin
      r = mlev_t'(-LEVEL_MAX);
    end else begin
      r = v[7:0];
    end
    return r;
  endfunction

  // Sign-magnitude drive byte; zero is sent as the negative-zero code
  function automatic code_t encode_level(mlev_t v);
    code_t r;
    mlev_t neg;
    neg = -v;
    if (v < 0) begin
      r = CODE_NEG | code_t'(neg);
    end else if (v == 0) begin
      r = CODE_NEG;
    end else begin
      r = code_t'(v);
    end
    return r;
  endfunction

endpackage

// ----- rtl/ordd_divider.sv -----
module ordd_divider import ordd_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] cnt_r, cnt_nxt;
  logic [DSR_W-1:0]  rem_r, rem_nxt;
  logic [DSR_W-1:0]  dsr_r, dsr_nxt;
  logic [DVD_W-1:0]  dvd_r, dvd_nxt;
  logic [DVD_W-1:0]  quo_r, quo_nxt;
  logic [DSR_W:0]    trial;
  logic [DSR_W:0]    diff;
  logic              fits;

  // One restoring step: bring down the next dividend bit, subtract if it fits
  always_comb begin
    trial = {rem_r, dvd_r[DVD_W-1]};
    fits  = trial >= {1'b0, dsr_r};
    diff  = trial - {1'b0, dsr_r};
  end

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    dsr_nxt  = dsr_r;
    dvd_nxt  = dvd_r;
    quo_nxt  = quo_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = req.steps;
      rem_nxt  = '0;
      dsr_nxt  = req.divisor;
      dvd_nxt  = req.dividend;
      quo_nxt  = '0;
    end else if (busy_r) begin
      rem_nxt = fits ? diff[DSR_W-1:0] : trial[DSR_W-1:0];
      quo_nxt = {quo_r[DVD_W-2:0], fits};
      dvd_nxt = {dvd_r[DVD_W-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == STEP_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    dsr_r <= dsr_nxt;
    dvd_r <= dvd_nxt;
    quo_r <= quo_nxt;
  end

  assign rsp.busy     = busy_r;
  assign rsp.done     = done_r;
  assign rsp.quotient = quo_r;

endmodule

// ----- rtl/ordd_select.sv -----
module ordd_select import ordd_pkg::*; (
  input  sel_in_t  sel_in,
  input  speed_t   speed,
  input  mlev_t    kept0,
  input  mlev_t    kept1,
  input  mlev_t    kept2,
  output sel_out_t sel_out
);

  lvl_t    full, half, quart, quart3;
  lvl_t    m0, m1, m2;
  logic    stop, long_hold;
  action_t act;

  // Speed ladder: full, half, quarter and three quarters (all truncating)
  assign full   = lvl_t'({2'b00, speed});
  assign half   = lvl_t'({3'b000, speed[SPEED_W-1:1]});
  assign quart  = lvl_t'({4'b0000, speed[SPEED_W-1:2]});
  assign quart3 = quart + (quart <<< 1);

  always_comb begin
    m0        = lvl_t'(kept0);
    m1        = lvl_t'(kept1);
    m2        = lvl_t'(kept2);
    stop      = 1'b0;
    long_hold = 1'b1;
    act       = sel_in.action;

    if (sel_in.line_r) begin
      // Right line: escape to the left
      stop = 1'b1;
      if (sel_in.line_b) begin
        m0 = -quart; m1 = -quart3; m2 = full;
      end else if (sel_in.action == ACT_CENTRE) begin
        m0 = -full; m1 = '0; m2 = full;
      end else if (sel_in.action == ACT_AUX) begin
        m0 = '0; m1 = -full; m2 = full;
      end else begin
        m0 = -half; m1 = -half; m2 = full;
      end
    end else if (sel_in.line_l) begin
      // Left line: escape to the right
      stop = 1'b1;
      if (sel_in.line_b) begin
        m0 = quart3; m1 = quart; m2 = -full;
      end else if (sel_in.action == ACT_CENTRE) begin
        m0 = '0; m1 = full; m2 = -full;
      end else if (sel_in.action == ACT_AUX) begin
        m0 = full; m1 = '0; m2 = -full;
      end else begin
        m0 = half; m1 = half; m2 = -full;
      end
    end else if (sel_in.line_b) begin
      // Back line: direction follows the last action, none keeps the old levels
      case (sel_in.action)
        ACT_CENTRE: begin stop = 1'b1; m0 = -full; m1 = full;  m2 = '0;    end
        ACT_UPPER:  begin stop = 1'b1; m0 = '0;    m1 = -full; m2 = full;  end
        ACT_LOWER:  begin stop = 1'b1; m0 = full;  m1 = '0;    m2 = -full; end
        ACT_AUX:    begin stop = 1'b1; m0 = full;  m1 = -full; m2 = '0;    end
        default:    begin stop = 1'b0; end
      endcase
    end else begin
      long_hold = 1'b0;
      if (sel_in.window) begin
        if (sel_in.ball_any) begin
          // Weighted average of front sensors picks the drive
          case (sel_in.avg)
            4'd2: begin m0 = -full;   m1 = '0;     m2 = full;  act = ACT_LOWER;  end
            4'd3: begin m0 = -quart3; m1 = -quart; m2 = full;  act = ACT_LOWER;  end
            4'd4: begin m0 = -half;   m1 = -half;  m2 = full;  act = ACT_LOWER;  end
            4'd5: begin m0 = '0;      m1 = -full;  m2 = full;  act = ACT_CENTRE; end
            4'd6: begin m0 = full;    m1 = -full;  m2 = '0;    act = ACT_CENTRE; end
            4'd7: begin m0 = full;    m1 = '0;     m2 = -full; act = ACT_CENTRE; end
            4'd8: begin m0 = half;    m1 = half;   m2 = -full; act = ACT_UPPER;  end
            4'd9: begin m0 = quart;   m1 = quart3; m2 = -full; act = ACT_UPPER;  end
            default: begin m0 = '0;   m1 = full;   m2 = -full; act = ACT_UPPER;  end
          endcase
        end else if (sel_in.rear_seen) begin
          // Ball behind: turn towards the brighter side, else keep levels
          if (sel_in.rear_ord_a) begin
            m0 = '0; m1 = full; m2 = -full;
          end else if (sel_in.rear_ord_b) begin
            m0 = -full; m1 = '0; m2 = full;
          end
        end else begin
          m0 = '0; m1 = '0; m2 = '0;
        end
      end else if (sel_in.dir_high) begin
        m0 = SLOW_LEVEL; m1 = SLOW_LEVEL; m2 = SLOW_LEVEL;
      end else begin
        m0 = -SLOW_LEVEL; m1 = -SLOW_LEVEL; m2 = -SLOW_LEVEL;
      end
    end
  end

  assign sel_out.stop      = stop;
  assign sel_out.long_hold = long_hold;
  assign sel_out.action    = act;
  assign sel_out.lv0       = m0;
  assign sel_out.lv1       = m1;
  assign sel_out.lv2       = m2;

endmodule

// ----- rtl/omni_robot_drive_decider.sv -----
// Drive decider for a three-wheel omni robot. Each input transaction is one
// sensor snapshot; each produces exactly one motor command (stop-first flag,
// three sign-magnitude drive bytes and a hold time). A line hit selects an
// escape set (old levels on a back line with no action) and a 500 ms hold;
// else the ball sensors steer inside the heading window and a slow level
// drives outside it; a heading correction is added unless every level is
// zero. Items are handled one at a time: in_stall is high from acceptance
// until S_APPLY loads the command into the output register, after S_DIR,
// S_CORR and S_AVG; S_APPLY waits while the output stalls. S_AVG waits for
// the single bit-serial divider (5 steps for the weighted sensor average);
// compass scaling and heading correction use reciprocal multiplications.
// The next snapshot may be accepted while the previous command still waits
// on out_stall. Configuration writes are always taken (cfg_ready is high)
// and must only be issued while the block is idle.
module omni_robot_drive_decider import ordd_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  in_item_t             in_data,
  output logic                 out_valid,
  input  logic                 out_stall,
  output out_item_t            out_data,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  limit_t               cfg_data
);

  typedef enum logic [4:0] {
    S_IDLE  = 5'b00001,
    S_DIR   = 5'b00010,
    S_CORR  = 5'b00100,
    S_AVG   = 5'b01000,
    S_APPLY = 5'b10000
  } state_t;

  state_t  state_r, state_nxt;
  limit_t  lim_r_r, lim_r_nxt;
  limit_t  lim_l_r, lim_l_nxt;
  limit_t  lim_b_r, lim_b_nxt;
  speed_t  speed_r, speed_nxt;
  action_t last_action_r, last_action_nxt;
  mlev_t   levels_r [3];
  mlev_t   levels_nxt [3];
  logic    out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  sel_in_t          flags_r, flags_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  wsum_t            wsum_r, wsum_nxt;
  dir_t             q_dir_r, q_dir_nxt;
  logic [MAG_W-1:0] mag_r, mag_nxt;
  logic             corr_neg_r, corr_neg_nxt;
  corr_t            corr_r, corr_nxt;

  div_req_t div_req;
  div_rsp_t div_rsp;
  sel_in_t  sel_in;
  sel_out_t sel_out;

  logic               in_fire, cfg_fire, apply_fire;
  logic               hit1, hit2, hit3, hit4, hit5;
  logic [HPROD_W-1:0] head_prod;
  dir_t               dir, corr_mag9;
  logic [CPROD_W-1:0] corr_prod;
  corr_t              corr_pos;
  logic               all_zero;
  lvl_t               corr_add;
  lvl_t               sum0, sum1, sum2;
  mlev_t              c0, c1, c2;

  assign in_fire    = in_valid && !in_stall;
  assign cfg_fire   = cfg_valid && cfg_ready;
  assign apply_fire = (state_r == S_APPLY) && (!out_valid_r || !out_stall);

  // Snapshot qualification at acceptance
  always_comb begin
    hit1 = in_data.ball_one   > BALL_ONE_LIM;
    hit2 = in_data.ball_two   > BALL_LIM;
    hit3 = in_data.ball_three > BALL_LIM;
    hit4 = in_data.ball_four  > BALL_LIM;
    hit5 = in_data.ball_five  > BALL_LIM;
    head_prod = HPROD_W'(in_data.heading_raw) * HEAD_RECIP;
  end

  // Heading: dir = q+180 wrapped, dir-180 = q or q-360
  always_comb begin
    dir       = (q_dir_r >= DIR_HALF) ? (q_dir_r - DIR_HALF) : (q_dir_r + DIR_HALF);
    corr_mag9 = (q_dir_r >= DIR_HALF) ? (DIR_FULL - q_dir_r) : q_dir_r;
    corr_prod = CPROD_W'(mag_r) * CORR_RECIP;
    corr_pos  = corr_t'({1'b0, corr_prod[CORR_SHIFT +: CORR_W-1]});
  end

  // Sequencer and divider requests
  always_comb begin
    state_nxt    = state_r;
    flags_nxt    = flags_r;
    cnt_nxt      = cnt_r;
    wsum_nxt     = wsum_r;
    q_dir_nxt    = q_dir_r;
    mag_nxt      = mag_r;
    corr_neg_nxt = corr_neg_r;
    corr_nxt     = corr_r;
    div_req      = '0;
    unique case (state_r)
      S_IDLE: begin
        if (in_fire) begin
          flags_nxt.line_r     = {1'b0, in_data.line_right} > lim_r_r;
          flags_nxt.line_l     = {1'b0, in_data.line_left}  > lim_l_r;
          flags_nxt.line_b     = {1'b0, in_data.line_back}  > lim_b_r;
          flags_nxt.rear_seen  = in_data.ball_rear > REAR_LIM;
          flags_nxt.rear_ord_a = (in_data.ball_rear > in_data.ball_five) &&
                                 (in_data.ball_five > in_data.ball_four);
          flags_nxt.rear_ord_b = (in_data.ball_rear > in_data.ball_four) &&
                                 (in_data.ball_four > in_data.ball_five);
          flags_nxt.ball_any   = hit1 | hit2 | hit3 | hit4 | hit5;
          flags_nxt.action     = ACT_NONE;
          cnt_nxt  = {2'b00, hit1} + {2'b00, hit2} + {2'b00, hit3} +
                     {2'b00, hit4} + {2'b00, hit5};
          wsum_nxt = (hit1 ? W_ONE : '0) + (hit2 ? W_TWO : '0) +
                     (hit3 ? W_THREE : '0) + (hit4 ? W_FOUR : '0) +
                     (hit5 ? W_FIVE : '0);
          q_dir_nxt = head_prod[HEAD_SHIFT +: DIR_W];
          state_nxt = S_DIR;
        end
      end
      S_DIR: begin
        // Window flags, correction magnitude; average division starts
        flags_nxt.window   = (dir > WIN_LO) && (dir < WIN_HI);
        flags_nxt.dir_high = dir > DIR_HALF;
        corr_neg_nxt       = q_dir_r >= DIR_HALF;
        mag_nxt            = corr_mag9[MAG_W-1:0];
        div_req.start    = 1'b1;
        div_req.dividend = wsum_r;
        div_req.divisor  = (cnt_r == '0) ? DSR_W'(1) : DSR_W'(cnt_r);
        div_req.steps    = STEPS_AVG;
        state_nxt = S_CORR;
      end
      S_CORR: begin
        corr_nxt  = corr_neg_r ? -corr_pos : corr_pos;
        state_nxt = S_AVG;
      end
      S_AVG: begin
        if (div_rsp.done) begin
          flags_nxt.avg = div_rsp.quotient[AVG_W-1:0];
          state_nxt = S_APPLY;
        end
      end
      S_APPLY: begin
        if (apply_fire) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  ordd_divider u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .rsp   (div_rsp)
  );

  // Decision: current flags with the stored action
  always_comb begin
    sel_in        = flags_r;
    sel_in.action = last_action_r;
  end

  ordd_select u_sel (
    .sel_in  (sel_in),
    .speed   (speed_r),
    .kept0   (levels_r[0]),
    .kept1   (levels_r[1]),
    .kept2   (levels_r[2]),
    .sel_out (sel_out)
  );

  // Heading correction, clamp and encoding
  always_comb begin
    all_zero = (sel_out.lv0 == '0) && (sel_out.lv1 == '0) && (sel_out.lv2 == '0);
    corr_add = all_zero ? lvl_t'(0) : lvl_t'(corr_r);
    sum0 = sel_out.lv0 + corr_add;
    sum1 = sel_out.lv1 + corr_add;
    sum2 = sel_out.lv2 + corr_add;
    c0 = clamp_level(sum0);
    c1 = clamp_level(sum1);
    c2 = clamp_level(sum2);
  end

  // State, output register and configuration
  always_comb begin
    last_action_nxt = last_action_r;
    levels_nxt      = levels_r;
    out_data_nxt    = out_data_r;
    out_valid_nxt   = out_valid_r && out_stall;
    if (apply_fire) begin
      last_action_nxt = sel_out.action;
      levels_nxt[0]   = c0;
      levels_nxt[1]   = c1;
      levels_nxt[2]   = c2;
      out_valid_nxt   = 1'b1;
      out_data_nxt.stop_first       = sel_out.stop;
      out_data_nxt.motor_one_code   = encode_level(c0);
      out_data_nxt.motor_two_code   = encode_level(c1);
      out_data_nxt.motor_three_code = encode_level(c2);
      out_data_nxt.hold_ms          = sel_out.long_hold ? HOLD_LINE : HOLD_BALL;
    end

    lim_r_nxt = lim_r_r;
    lim_l_nxt = lim_l_r;
    lim_b_nxt = lim_b_r;
    speed_nxt = speed_r;
    if (cfg_fire) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_LIM_RIGHT: lim_r_nxt = cfg_data;
        REG_LIM_LEFT:  lim_l_nxt = cfg_data;
        REG_LIM_BACK:  lim_b_nxt = cfg_data;
        REG_SPEED:     speed_nxt = cfg_data[SPEED_W-1:0];
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      out_valid_r   <= 1'b0;
      last_action_r <= ACT_NONE;
      levels_r[0]   <= '0;
      levels_r[1]   <= '0;
      levels_r[2]   <= '0;
      lim_r_r       <= LIM_RESET;
      lim_l_r       <= LIM_RESET;
      lim_b_r       <= LIM_RESET;
      speed_r       <= SPEED_RESET;
    end else begin
      state_r       <= state_nxt;
      out_valid_r   <= out_valid_nxt;
      last_action_r <= last_action_nxt;
      levels_r      <= levels_nxt;
      lim_r_r       <= lim_r_nxt;
      lim_l_r       <= lim_l_nxt;
      lim_b_r       <= lim_b_nxt;
      speed_r       <= speed_nxt;
    end
  end

  always_ff @(posedge clk) begin
    flags_r    <= flags_nxt;
    cnt_r      <= cnt_nxt;
    wsum_r     <= wsum_nxt;
    q_dir_r    <= q_dir_nxt;
    mag_r      <= mag_nxt;
    corr_neg_r <= corr_neg_nxt;
    corr_r     <= corr_nxt;
    out_data_r <= out_data_nxt;
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign cfg_ready = 1'b1;

  // Checks
  a_idle_div_free: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_IDLE) |-> !div_rsp.busy)
    else $error("divider busy while sequencer idle");

  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (state_r == S_DIR) ##1 div_rsp.busy)
    else $error("accepted transaction did not start the sensor average");

  a_action_range: assert property (@(posedge clk) disable iff (!rst_n)
    last_action_r <= ACT_AUX)
    else $error("stored action out of range");

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (levels_r[0] <= mlev_t'(LEVEL_MAX)) && (levels_r[0] >= mlev_t'(-LEVEL_MAX)) &&
    (levels_r[1] <= mlev_t'(LEVEL_MAX)) && (levels_r[1] >= mlev_t'(-LEVEL_MAX)) &&
    (levels_r[2] <= mlev_t'(LEVEL_MAX)) && (levels_r[2] >= mlev_t'(-LEVEL_MAX)))
    else $error("stored motor level outside clamp range");

endmodule
